@@ design/salwc_pkg.sv @@
// Shared constants, types and helpers of the LRU write-back cache model.
`timescale 1ns / 1ps
package salwc_pkg;

   localparam int SET_BITS_MAX_DEF = 8;
   localparam int WAYS_DEF         = 8;
   localparam int AGE_WIDTH_DEF    = 32;
   localparam int ADDR_WIDTH_DEF   = 64;

   localparam int TOT_W  = 48;   // running totals
   localparam int DNOW_W = 42;   // current dirty bytes
   localparam int SB_W   = 4;
   localparam int BB_W   = 5;
   localparam int WY_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int WEFF_W = 6;    // effective way count, up to 15

   localparam logic [BB_W-1:0] BLOCK_BITS_TOP = 5'd30;
   localparam logic            OP_STORE       = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   typedef struct packed {
      logic [SB_W-1:0] set_bits;
      logic [BB_W-1:0] block_bits;
      logic [WY_W-1:0] ways_in_use;
   } cfg_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   function automatic logic [BB_W-1:0] eff_block_bits(input cfg_type c);
      eff_block_bits = (c.block_bits > BLOCK_BITS_TOP) ? BLOCK_BITS_TOP : c.block_bits;
   endfunction

   function automatic logic [TOT_W-1:0] sat_add48(input logic [TOT_W-1:0] a,
                                                  input logic [TOT_W-1:0] b);
      logic [TOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add48 = s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
   endfunction

endpackage

@@ design/salwc_front.sv @@
// Front stage: takes an access and splits the address into set index and tag.
`timescale 1ns / 1ps
module salwc_front #(
   parameter int SET_BITS_MAX = salwc_pkg::SET_BITS_MAX_DEF,
   parameter int ADDR_WIDTH   = salwc_pkg::ADDR_WIDTH_DEF,
   parameter int SET_W        = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1,
   parameter int ENT_W        = 1 + SET_W + ADDR_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  salwc_pkg::cfg_type    cfg,
   input  logic                  hold,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_store,
   input  logic [ADDR_WIDTH-1:0] in_addr,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [ENT_W-1:0]      out_entry
);

   logic                  vld_ff, vld_in;
   logic [ENT_W-1:0]      ent_ff;
   logic [ENT_W-1:0]      ent_in;
   logic [salwc_pkg::BB_W-1:0] bb;
   logic [5:0]            sb;
   logic [SET_W-1:0]      set_idx;
   logic [ADDR_WIDTH-1:0] tag;

   always_comb begin
      bb = salwc_pkg::eff_block_bits(cfg);
      sb = (6'(cfg.set_bits) > 6'(SET_BITS_MAX)) ? 6'(SET_BITS_MAX) : 6'(cfg.set_bits);
      set_idx = SET_W'(in_addr >> bb) & ~({SET_W{1'b1}} << sb);
      if (SET_BITS_MAX == 0) begin
         set_idx = '0;
      end
      tag = in_addr >> (7'(sb) + 7'(bb));
      ent_in = {in_store, set_idx, tag};
      in_ready = !hold && (!vld_ff || out_ready);
      vld_in = vld_ff && !out_ready;
      if (in_valid && in_ready) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (in_valid && in_ready) begin
         ent_ff <= ent_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_entry = ent_ff;

endmodule

@@ design/salwc_queue.sv @@
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module salwc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             not_full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;

   assign not_full  = (cnt_ff != 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && not_full) wp_ff <= ~wp_ff;
         if (pop && not_empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'((push && not_full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
      end
      if (push && not_full) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

endmodule

@@ design/salwc_back.sv @@
// Back part: set lookup, LRU update, fill or eviction, totals and result register.
`timescale 1ns / 1ps
module salwc_back #(
   parameter int SET_BITS_MAX = salwc_pkg::SET_BITS_MAX_DEF,
   parameter int WAYS         = salwc_pkg::WAYS_DEF,
   parameter int AGE_WIDTH    = salwc_pkg::AGE_WIDTH_DEF,
   parameter int ADDR_WIDTH   = salwc_pkg::ADDR_WIDTH_DEF,
   parameter int SET_W        = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1,
   parameter int ENT_W        = 1 + SET_W + ADDR_WIDTH,
   parameter int RSP_W        = 240
) (
   input  logic               clock,
   input  logic               reset,
   input  salwc_pkg::cfg_type cfg,
   output logic               clearing,
   input  logic               q_valid,
   output logic               q_pop,
   input  logic [ENT_W-1:0]   q_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_outcome,
   output logic [RSP_W-1:0]   rsp_data
);

   localparam int ROWS  = 2 ** SET_W;
   localparam int LINES = WAYS << SET_BITS_MAX;
   localparam int CNT_W = $clog2(LINES + 1);
   localparam int WIX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TW    = salwc_pkg::TOT_W;
   localparam int DW    = salwc_pkg::DNOW_W;
   localparam int PAD   = RSP_W - 1 - 4 * TW - DW;

   // set storage, one row per set
   logic [WAYS-1:0]                 valid_mem [ROWS];
   logic [WAYS-1:0]                 dirty_mem [ROWS];
   logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_mem   [ROWS];
   logic [WAYS-1:0][AGE_WIDTH-1:0]  age_mem   [ROWS];

   logic [WAYS-1:0]                 rd_valid_ff, rd_dirty_ff;
   logic [WAYS-1:0][ADDR_WIDTH-1:0] rd_tag_ff;
   logic [WAYS-1:0][AGE_WIDTH-1:0]  rd_age_ff;

   salwc_pkg::back_state_type state_ff, state_in;
   logic [SET_W:0]        clr_ff, clr_in;
   logic                  it_store_ff;
   logic [SET_W-1:0]      it_set_ff;
   logic [ADDR_WIDTH-1:0] it_tag_ff;

   logic [TW-1:0]    hits_ff, hits_in, miss_ff, miss_in, evs_ff, evs_in, deb_ff, deb_in;
   logic [CNT_W-1:0] dcnt_ff, dcnt_in;

   logic             rsp_valid_ff;
   logic [1:0]       rsp_out_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic                            we, commit, rd_en;
   logic [SET_W-1:0]                waddr;
   logic [WAYS-1:0]                 w_valid, w_dirty;
   logic [WAYS-1:0][ADDR_WIDTH-1:0] w_tag;
   logic [WAYS-1:0][AGE_WIDTH-1:0]  w_age, age_nx;
   logic [WAYS-1:0]                 inuse, match;
   logic [salwc_pkg::WEFF_W-1:0]    ways_eff;
   logic [salwc_pkg::BB_W-1:0]      bb;
   logic                            hit, have_empty, ev_dirty, old_dirty;
   logic [WIX_W-1:0]                empty_idx, vic_idx, fill_idx;
   logic [AGE_WIDTH-1:0]            best_age;
   logic [CNT_W-1:0]                inc;
   logic [1:0]                      outcome;
   logic [63:0]                     dbytes;

   always_comb begin
      bb = salwc_pkg::eff_block_bits(cfg);
      ways_eff = (cfg.ways_in_use == '0) ? salwc_pkg::WEFF_W'(1) :
                 salwc_pkg::WEFF_W'(cfg.ways_in_use);
      if (ways_eff > salwc_pkg::WEFF_W'(WAYS)) ways_eff = salwc_pkg::WEFF_W'(WAYS);

      // tag compare and aging over the ways in use
      for (int w = 0; w < WAYS; w++) begin
         inuse[w] = salwc_pkg::WEFF_W'(w) < ways_eff;
         match[w] = inuse[w] && rd_valid_ff[w] && (rd_tag_ff[w] == it_tag_ff);
         age_nx[w] = rd_age_ff[w];
         if (match[w]) begin
            age_nx[w] = '0;
         end else if (inuse[w] && rd_valid_ff[w] && (rd_age_ff[w] != {AGE_WIDTH{1'b1}})) begin
            age_nx[w] = rd_age_ff[w] + AGE_WIDTH'(1);
         end
      end
      hit = |match;

      // lowest empty way
      have_empty = 1'b0;
      empty_idx  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (inuse[w] && !rd_valid_ff[w]) begin
            have_empty = 1'b1;
            empty_idx  = WIX_W'(w);
         end
      end

      // oldest way, ties to the lowest
      vic_idx  = '0;
      best_age = age_nx[0];
      for (int w = 1; w < WAYS; w++) begin
         if (inuse[w] && (age_nx[w] > best_age)) begin
            vic_idx  = WIX_W'(w);
            best_age = age_nx[w];
         end
      end
      fill_idx = have_empty ? empty_idx : vic_idx;

      inc = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (match[w] && it_store_ff && !rd_dirty_ff[w]) inc = inc + CNT_W'(1);
      end

      w_valid   = rd_valid_ff;
      w_dirty   = rd_dirty_ff | (match & {WAYS{it_store_ff}});
      w_tag     = rd_tag_ff;
      w_age     = age_nx;
      old_dirty = rd_dirty_ff[fill_idx];
      ev_dirty  = 1'b0;
      dcnt_in   = dcnt_ff + inc;
      hits_in   = hits_ff;
      miss_in   = miss_ff;
      evs_in    = evs_ff;
      deb_in    = deb_ff;
      if (hit) begin
         outcome = salwc_pkg::OUT_HIT;
         hits_in = salwc_pkg::sat_add48(hits_ff, TW'(1));
      end else begin
         miss_in = salwc_pkg::sat_add48(miss_ff, TW'(1));
         w_valid[fill_idx] = 1'b1;
         w_tag[fill_idx]   = it_tag_ff;
         w_age[fill_idx]   = '0;
         w_dirty[fill_idx] = it_store_ff;
         if (it_store_ff && !old_dirty) dcnt_in = dcnt_ff + CNT_W'(1);
         if (have_empty) begin
            outcome = salwc_pkg::OUT_FILL;
         end else begin
            outcome  = salwc_pkg::OUT_EVICT;
            evs_in   = salwc_pkg::sat_add48(evs_ff, TW'(1));
            ev_dirty = old_dirty;
            if (old_dirty) begin
               deb_in = salwc_pkg::sat_add48(deb_ff, TW'(64'd1 << bb));
               if (!it_store_ff) dcnt_in = dcnt_ff - CNT_W'(1);
            end
         end
      end
      dbytes = 64'(dcnt_in) << bb;

      // sequencer
      state_in = state_ff;
      clr_in   = clr_ff;
      commit   = 1'b0;
      rd_en    = 1'b0;
      we       = 1'b0;
      waddr    = it_set_ff;
      unique case (state_ff)
         salwc_pkg::BK_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff[SET_W-1:0];
            clr_in = clr_ff + (SET_W+1)'(1);
            if (clr_ff == (SET_W+1)'(ROWS - 1)) state_in = salwc_pkg::BK_IDLE;
         end
         salwc_pkg::BK_IDLE: begin
            if (q_valid) begin
               rd_en    = 1'b1;
               state_in = salwc_pkg::BK_EXEC;
            end
         end
         salwc_pkg::BK_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit   = 1'b1;
               we       = 1'b1;
               state_in = salwc_pkg::BK_IDLE;
            end
         end
         default: state_in = salwc_pkg::BK_CLEAR;
      endcase
      if (state_ff == salwc_pkg::BK_CLEAR) begin
         w_valid = '0;
         w_dirty = '0;
         w_tag   = '0;
         w_age   = '0;
      end
   end

   assign q_pop       = rd_en;
   assign clearing    = (state_ff == salwc_pkg::BK_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_out_ff;
   assign rsp_data    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         valid_mem[waddr] <= w_valid;
         dirty_mem[waddr] <= w_dirty;
         tag_mem[waddr]   <= w_tag;
         age_mem[waddr]   <= w_age;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_mem[q_entry[ADDR_WIDTH +: SET_W]];
         rd_dirty_ff <= dirty_mem[q_entry[ADDR_WIDTH +: SET_W]];
         rd_tag_ff   <= tag_mem[q_entry[ADDR_WIDTH +: SET_W]];
         rd_age_ff   <= age_mem[q_entry[ADDR_WIDTH +: SET_W]];
         it_store_ff <= q_entry[ENT_W-1];
         it_set_ff   <= q_entry[ADDR_WIDTH +: SET_W];
         it_tag_ff   <= q_entry[ADDR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salwc_pkg::BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         evs_ff       <= '0;
         deb_ff       <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            hits_ff      <= hits_in;
            miss_ff      <= miss_in;
            evs_ff       <= evs_in;
            deb_ff       <= deb_in;
            dcnt_ff      <= dcnt_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (commit) begin
         rsp_out_ff  <= outcome;
         rsp_data_ff <= {PAD'(0), dbytes[DW-1:0], deb_in, evs_in, miss_in, hits_in, ev_dirty};
      end
   end

endmodule

@@ design/set_assoc_lru_writeback_cache_model_unit.sv @@
// Top level of the set-associative LRU write-back cache model.
`timescale 1ns / 1ps
// Usage:
//  req_*  : one access per transfer; tuser is the opcode (0 load, 1 store),
//           tdata the byte address.
//  rsp_*  : one result per access, in order; tuser is the outcome
//           (hit, fill of an empty way, eviction), tdata the eviction flag
//           and the running totals.
//  csr_*  : register writes (0 set_bits, 1 block_bits, 2 ways_in_use),
//           taken every cycle; index 3 is ignored. Write only when idle.
// Path: an access passes the front register, which loads on the transfer
//   edge itself, then the queue push, the set read and the update before it
//   reaches the result register.
// Sequencing: the back sequencer takes a new access only after the last is
//   written back; its idle state reads the set row, its exec state compares,
//   updates LRU and writes it back, so a same-set access sees the last update.
// Reset: after reset a clearing pass zeroes the valid, dirty, tag and age
//   rows of every set; req_tready stays low during it.
// Stalls: a held result blocks the back part only; the two-entry queue and
//   the front register keep taking accesses until they fill up.
module set_assoc_lru_writeback_cache_model_unit #(
   parameter int SET_BITS_MAX = salwc_pkg::SET_BITS_MAX_DEF,
   parameter int WAYS         = salwc_pkg::WAYS_DEF,
   parameter int AGE_WIDTH    = salwc_pkg::AGE_WIDTH_DEF,
   parameter int ADDR_WIDTH   = salwc_pkg::ADDR_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((ADDR_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // address
   input  logic                                  req_tuser,  // opcode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // evicted_dirty, hit_total, miss_total, eviction_total,
   // dirty_evicted_bytes, dirty_bytes_now, zero fill
   output logic [239:0]                          rsp_tdata,
   output logic [1:0]                            rsp_tuser,  // outcome
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [salwc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [salwc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SET_W = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
   localparam int ENT_W = 1 + SET_W + ADDR_WIDTH;

   salwc_pkg::cfg_type cfg_ff;
   logic               clearing;
   logic               f_valid, q_not_full, q_not_empty, q_pop;
   logic [ENT_W-1:0]   f_entry, q_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits    <= salwc_pkg::SB_W'(4);
         cfg_ff.block_bits  <= salwc_pkg::BB_W'(4);
         cfg_ff.ways_in_use <= salwc_pkg::WY_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            salwc_pkg::CSR_SET_BITS:   cfg_ff.set_bits    <= csr_data[salwc_pkg::SB_W-1:0];
            salwc_pkg::CSR_BLOCK_BITS: cfg_ff.block_bits  <= csr_data;
            salwc_pkg::CSR_WAYS:       cfg_ff.ways_in_use <= csr_data[salwc_pkg::WY_W-1:0];
            default: ;
         endcase
      end
   end

   salwc_front #(
      .SET_BITS_MAX (SET_BITS_MAX),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .hold      (clearing),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_store  (req_tuser),
      .in_addr   (req_tdata[ADDR_WIDTH-1:0]),
      .out_valid (f_valid),
      .out_ready (q_not_full),
      .out_entry (f_entry)
   );

   salwc_queue #(
      .WIDTH (ENT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .not_full  (q_not_full),
      .push_data (f_entry),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_entry)
   );

   salwc_back #(
      .SET_BITS_MAX (SET_BITS_MAX),
      .WAYS         (WAYS),
      .AGE_WIDTH    (AGE_WIDTH),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .clearing    (clearing),
      .q_valid     (q_not_empty),
      .q_pop       (q_pop),
      .q_entry     (q_entry),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_outcome (rsp_tuser),
      .rsp_data    (rsp_tdata)
   );

   // no access taken while the set rows are being cleared
   assert property (@(posedge clock) disable iff (reset) clearing |-> !req_tready)
      else $error("access taken during clearing pass");

   // only an eviction can report a dirty victim
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != salwc_pkg::OUT_EVICT) |-> !rsp_tdata[0])
      else $error("dirty flag without eviction");

   // the back part never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_not_empty)
      else $error("pop from empty queue");

endmodule
